/* hdl/plse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plse_pkg
// Shared types and constants of the logic stack executor.
// ----------------------------------------------------------------------------
package plse_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int COIL_COUNT  = 4;

   typedef enum logic [3:0] {
      OP_LD  = 4'd0,
      OP_LDN = 4'd1,
      OP_A   = 4'd2,
      OP_AN  = 4'd3,
      OP_ALD = 4'd4,
      OP_O   = 4'd5,
      OP_ON  = 4'd6,
      OP_OLD = 4'd7,
      OP_OUT = 4'd8
   } opcode_type;

   // upper two bits of a symbol select its group
   localparam logic [1:0] SYM_INPUT_GROUP = 2'b00;
   localparam logic [1:0] SYM_COIL_GROUP  = 2'b10;

   typedef struct packed {
      logic push;
      logic pop;
      logic comb;
      logic clear;
      logic head_level;
   } cell_ctrl_type;

   typedef struct packed {
      logic [COIL_COUNT-1:0] coil_levels;
      logic                  top_bit;
      logic                  stack_error;
   } rsp_word_type;

endpackage

/* hdl/plse_intf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plse_req_if / plse_rsp_if
// Valid/ready channels for instruction words and result words.
// ----------------------------------------------------------------------------
interface plse_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] mode;
   logic [3:0] operand;
   logic [3:0] input_levels;

   modport source (output valid, output mode, output operand, output input_levels,
                   input ready);
   modport sink (input valid, input mode, input operand, input input_levels,
                 output ready);
endinterface

interface plse_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] coil_levels;
   logic       top_bit;
   logic       stack_error;

   modport source (output valid, output coil_levels, output top_bit,
                   output stack_error, input ready);
   modport sink (input valid, input coil_levels, input top_bit, input stack_error,
                 output ready);
endinterface

/* hdl/plc_logic_stack_executor_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_logic_stack_executor_top
// Instruction-list logic stack executor: one word per cycle while ready is high.
// ----------------------------------------------------------------------------
// Takes one instruction word per clock cycle and returns one result word for
// each, in order, from a registered result buffer. The stack is a row of
// cells, top of stack in the first cell, that all shift in the same cycle on
// a push or a pop, so every instruction finishes in the cycle it is taken. A
// two-word result buffer lets instructions keep flowing while the result
// side stalls; request ready drops only when both buffered words are still
// waiting.
module plc_logic_stack_executor_top (
   input  logic      clock,
   input  logic      reset,
   plse_req_if.sink  req_chan,
   plse_rsp_if.source rsp_chan
);

   localparam int N = plse_pkg::STACK_DEPTH;

   plse_pkg::cell_ctrl_type ctrl;
   plse_pkg::rsp_word_type  rsp_word;
   plse_pkg::rsp_word_type  buf_word;
   logic [N-1:0] cell_level;
   logic [N-1:0] cell_valid;
   logic [N-1:0] cell_bottom;
   logic [plse_pkg::COIL_COUNT-1:0] coil_ff, coil_in;
   logic       accept;
   logic       in_ready;
   logic       sym_level;
   logic       contact;
   logic       err;
   logic       do_push, do_pop, do_comb, do_clear;
   logic       head_level;
   logic       top_now;
   logic       bottom_level;
   logic [1:0] sym_idx;

   assign accept       = req_chan.valid && in_ready;
   assign req_chan.ready = in_ready;
   assign sym_idx      = req_chan.operand[1:0];
   assign top_now      = cell_valid[0] & cell_level[0];
   assign bottom_level = |cell_bottom;

   always_comb begin
      unique case (req_chan.operand[3:2])
         plse_pkg::SYM_INPUT_GROUP: sym_level = req_chan.input_levels[sym_idx];
         plse_pkg::SYM_COIL_GROUP:  sym_level = coil_ff[sym_idx];
         default:                   sym_level = 1'b0;
      endcase
   end

   always_comb begin
      err        = 1'b0;
      do_push    = 1'b0;
      do_pop     = 1'b0;
      do_comb    = 1'b0;
      do_clear   = 1'b0;
      head_level = 1'b0;
      contact    = sym_level;
      unique case (plse_pkg::opcode_type'(req_chan.mode))
         plse_pkg::OP_LD, plse_pkg::OP_LDN: begin
            err        = cell_valid[N-1];
            do_push    = 1'b1;
            head_level = (req_chan.mode == plse_pkg::OP_LDN) ? ~sym_level : sym_level;
         end
         plse_pkg::OP_A, plse_pkg::OP_AN, plse_pkg::OP_O, plse_pkg::OP_ON: begin
            err     = ~cell_valid[0];
            do_comb = 1'b1;
            if (req_chan.mode == plse_pkg::OP_AN || req_chan.mode == plse_pkg::OP_ON) begin
               contact = ~sym_level;
            end
            if (req_chan.mode == plse_pkg::OP_A || req_chan.mode == plse_pkg::OP_AN) begin
               head_level = cell_level[0] & contact;
            end else begin
               head_level = cell_level[0] | contact;
            end
         end
         plse_pkg::OP_ALD, plse_pkg::OP_OLD: begin
            err    = ~cell_valid[1];
            do_pop = 1'b1;
            if (req_chan.mode == plse_pkg::OP_ALD) begin
               head_level = cell_level[1] & cell_level[0];
            end else begin
               head_level = cell_level[1] | cell_level[0];
            end
         end
         plse_pkg::OP_OUT: begin
            err      = ~cell_valid[0];
            do_clear = 1'b1;
         end
         default: begin
            err = 1'b1;
         end
      endcase
   end

   always_comb begin
      ctrl.push       = accept && !err && do_push;
      ctrl.pop        = accept && !err && do_pop;
      ctrl.comb       = accept && !err && do_comb;
      ctrl.clear      = accept && !err && do_clear;
      ctrl.head_level = head_level;
   end

   always_comb begin
      coil_in = coil_ff;
      if (ctrl.clear && req_chan.operand[3:2] == plse_pkg::SYM_COIL_GROUP) begin
         coil_in[sym_idx] = bottom_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coil_ff <= '0;
      end else begin
         coil_ff <= coil_in;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_cell
         logic above_level, above_valid, below_level, below_valid;
         if (gi == 0) begin : g_first
            assign above_level = head_level;
            assign above_valid = 1'b1;
         end else begin : g_mid_above
            assign above_level = cell_level[gi-1];
            assign above_valid = cell_valid[gi-1];
         end
         if (gi == N-1) begin : g_last
            assign below_level = 1'b0;
            assign below_valid = 1'b0;
         end else begin : g_mid_below
            assign below_level = cell_level[gi+1];
            assign below_valid = cell_valid[gi+1];
         end
         plse_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .is_head     (gi == 0),
            .above_level (above_level),
            .above_valid (above_valid),
            .below_level (below_level),
            .below_valid (below_valid),
            .level       (cell_level[gi]),
            .valid       (cell_valid[gi]),
            .bottom      (cell_bottom[gi])
         );
      end
   endgenerate

   always_comb begin
      rsp_word.coil_levels = coil_in;
      rsp_word.stack_error = err;
      if (err) begin
         rsp_word.top_bit = top_now;
      end else if (do_clear) begin
         rsp_word.top_bit = 1'b0;
      end else begin
         rsp_word.top_bit = head_level;
      end
   end

   plse_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_word   (rsp_word),
      .in_ready  (in_ready),
      .out_valid (rsp_chan.valid),
      .out_word  (buf_word),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.coil_levels = buf_word.coil_levels;
   assign rsp_chan.top_bit     = buf_word.top_bit;
   assign rsp_chan.stack_error = buf_word.stack_error;

endmodule

/* hdl/plse_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plse_cell
// One stack position: a level bit and an occupancy bit, shifting with its
// neighbors on push and pop.
// ----------------------------------------------------------------------------
module plse_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  plse_pkg::cell_ctrl_type ctrl,
   input  logic                    is_head,
   input  logic                    above_level,
   input  logic                    above_valid,
   input  logic                    below_level,
   input  logic                    below_valid,
   output logic                    level,
   output logic                    valid,
   output logic                    bottom
);

   logic level_ff, level_in;
   logic valid_ff, valid_in;

   always_comb begin
      level_in = level_ff;
      valid_in = valid_ff;
      priority if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (is_head && (ctrl.push || ctrl.pop || ctrl.comb)) begin
         level_in = ctrl.head_level;
         valid_in = 1'b1;
      end else if (ctrl.push) begin
         level_in = above_level;
         valid_in = above_valid;
      end else if (ctrl.pop) begin
         level_in = below_level;
         valid_in = below_valid;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign level  = level_ff;
   assign valid  = valid_ff;
   // high when this is the deepest occupied entry and its level is set
   assign bottom = level_ff & valid_ff & ~below_valid;

endmodule

/* hdl/plse_rsp_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plse_rsp_buf
// Two-word result buffer between the stack update and the result channel.
// ----------------------------------------------------------------------------
module plse_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  plse_pkg::rsp_word_type in_word,
   output logic                   in_ready,
   output logic                   out_valid,
   output plse_pkg::rsp_word_type out_word,
   input  logic                   out_ready
);

   plse_pkg::rsp_word_type word0_ff, word0_in;
   plse_pkg::rsp_word_type word1_ff, word1_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic       push;
   logic [1:0] slot;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word  = word0_ff;
   assign pop       = out_valid && out_ready;
   assign push      = in_valid && in_ready;
   assign slot      = count_ff - {1'b0, pop};

   always_comb begin
      word0_in = word0_ff;
      word1_in = word1_ff;
      if (pop) begin
         word0_in = word1_ff;
      end
      if (push) begin
         if (slot == 2'd0) begin
            word0_in = in_word;
         end else begin
            word1_in = in_word;
         end
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      word0_ff <= word0_in;
      word1_ff <= word1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

/* hdl/plse_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plse_checker
// Port-level checks of the logic stack executor, bound to the top level.
// ----------------------------------------------------------------------------
module plse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [3:0] req_mode,
   input logic [3:0] req_operand,
   input logic [3:0] req_input_levels,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_coil_levels,
   input logic       rsp_top_bit,
   input logic       rsp_stack_error
);

   // no word comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown after reset");

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coil_levels)
         && $stable(rsp_top_bit) && $stable(rsp_stack_error))
      else $error("stalled result word changed");

   // unknown opcode reports an error
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode > plse_pkg::OP_OUT && !rsp_valid
         |=> rsp_valid && rsp_stack_error)
      else $error("unknown opcode not flagged");

   // load of an input puts that input on top unless rejected
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == plse_pkg::OP_LD
         && req_operand[3:2] == plse_pkg::SYM_INPUT_GROUP && !rsp_valid
         |=> rsp_valid && (rsp_stack_error
            || rsp_top_bit == $past(req_input_levels[req_operand[1:0]])))
      else $error("loaded input not on top of stack");

endmodule

bind plc_logic_stack_executor_top plse_checker u_plse_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_mode         (req_chan.mode),
   .req_operand      (req_chan.operand),
   .req_input_levels (req_chan.input_levels),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_coil_levels  (rsp_chan.coil_levels),
   .rsp_top_bit      (rsp_chan.top_bit),
   .rsp_stack_error  (rsp_chan.stack_error)
);
